// ----- design/glt_pkg.sv -----
// ----------------------------------------------------------------------------
// glt_pkg
// Shared constants, types and elaboration-time functions for the GELU core.
// ----------------------------------------------------------------------------
package glt_pkg;

    // Default configuration of the core.
    localparam int LUT_ENTRIES_DEF   = 128;
    localparam int SAMPLE_WIDTH_DEF  = 16;
    localparam int FRACTION_BITS_DEF = 11;

    // Coefficients in Q.24: 0.797885 and 0.044715.
    localparam int unsigned COEF_A = 13386289;
    localparam int unsigned COEF_B = 750193;
    localparam int COEF_A_WIDTH = 24;
    localparam int COEF_B_WIDTH = 20;
    localparam int COEF_SHIFT   = 24;

    // Tanh values are unsigned Q.30.
    localparam int Q30_SHIFT    = 30;
    localparam int TANH_WIDTH   = 30;
    localparam int SERIES_TERMS = 20;

    // Stage enables handed to the tanh lookup unit.
    typedef struct packed {
        logic index;
        logic fetch;
        logic blend;
    } glt_stage_en_t;

    // Restoring division, used only while the tanh table is built.
    function automatic longint unsigned glt_udiv(longint unsigned num,
                                                 longint unsigned den);
        longint unsigned rem;
        longint unsigned quo;
        rem = 0;
        quo = 0;
        for (int b = 63; b >= 0; b--) begin
            rem = (rem << 1) | ((num >> b) & 64'd1);
            if (rem >= den) begin
                rem = rem - den;
                quo = quo | (64'd1 << b);
            end
        end
        return quo;
    endfunction

    // Tanh at point i*4/(n-1) in Q.30, from a truncating exp series.
    function automatic logic [TANH_WIDTH-1:0] glt_tanh_entry(int i, int n);
        longint unsigned one;
        longint unsigned s;
        longint unsigned sum;
        longint unsigned term;
        longint unsigned d;
        one  = 64'd1 << Q30_SHIFT;
        s    = glt_udiv(longint'(i) << Q30_SHIFT, longint'(n - 1));
        sum  = one;
        term = one;
        for (int k = 1; k <= SERIES_TERMS; k++) begin
            term = glt_udiv((term * s) >> Q30_SHIFT, longint'(k));
            sum  = sum + term;
        end
        d = glt_udiv(64'd1 << 60, sum);
        for (int r = 0; r < 3; r++) begin
            d = (d * d) >> Q30_SHIFT;
        end
        if (d > one) begin
            d = one;
        end
        return TANH_WIDTH'(glt_udiv((one - d) << Q30_SHIFT, one + d));
    endfunction

endpackage

// ----- design/glt_tanh_interp.sv -----
// ----------------------------------------------------------------------------
// glt_tanh_interp
// Three-stage tanh magnitude: table index, table fetch, linear blend.
// ----------------------------------------------------------------------------
module glt_tanh_interp import glt_pkg::*; #(
    parameter int LUT_ENTRIES   = LUT_ENTRIES_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                      aclk,
    input  glt_stage_en_t             stage_en,
    input  logic [FRACTION_BITS+4:0]  arg,
    output logic [TANH_WIDTH:0]       tanh_mag
);

    localparam int F  = FRACTION_BITS;
    localparam int IW = $clog2(LUT_ENTRIES);
    localparam int FW = F + 2;

    // Constant tanh table.
    logic [TANH_WIDTH-1:0] rom [LUT_ENTRIES];
    for (genvar g = 0; g < LUT_ENTRIES; g++) begin : g_rom
        assign rom[g] = glt_tanh_entry(g, LUT_ENTRIES);
    end

    // Index stage: scale the argument onto the table grid.
    logic [FW+IW-1:0] pos;
    logic [IW-1:0]    idx_raw;
    logic [IW-1:0]    idx_reg;
    logic [FW-1:0]    frac_reg;
    logic             sat_idx_reg;

    assign pos     = (FW+IW)'(arg[FW-1:0]) * (FW+IW)'(LUT_ENTRIES - 1);
    assign idx_raw = pos[FW+IW-1:FW];

    always_ff @(posedge aclk) begin
        if (stage_en.index) begin
            idx_reg     <= (idx_raw > IW'(LUT_ENTRIES - 2)) ? IW'(LUT_ENTRIES - 2) : idx_raw;
            frac_reg    <= pos[FW-1:0];
            sat_idx_reg <= (arg[F+4:FW] != '0);
        end
    end

    // Fetch stage: read both neighbors and form the difference magnitude.
    logic [TANH_WIDTH-1:0] y0;
    logic [TANH_WIDTH-1:0] y1;
    logic [TANH_WIDTH-1:0] y0_reg;
    logic [TANH_WIDTH-1:0] diff_reg;
    logic                  up_reg;
    logic [FW-1:0]         frac_f_reg;
    logic                  sat_f_reg;

    assign y0 = rom[idx_reg];
    assign y1 = rom[idx_reg + IW'(1)];

    always_ff @(posedge aclk) begin
        if (stage_en.fetch) begin
            y0_reg     <= y0;
            up_reg     <= (y1 >= y0);
            diff_reg   <= (y1 >= y0) ? (y1 - y0) : (y0 - y1);
            frac_f_reg <= frac_reg;
            sat_f_reg  <= sat_idx_reg;
        end
    end

    // Blend stage: weight the difference by the fraction.
    logic [FW+TANH_WIDTH-1:0] dprod;
    logic [TANH_WIDTH-1:0]    step;
    logic [TANH_WIDTH:0]      blend;
    logic [TANH_WIDTH:0]      tanh_mag_reg;

    assign dprod = (FW+TANH_WIDTH)'(frac_f_reg) * (FW+TANH_WIDTH)'(diff_reg);
    assign step  = dprod[FW+TANH_WIDTH-1:FW];
    assign blend = up_reg ? ({1'b0, y0_reg} + {1'b0, step})
                          : ({1'b0, y0_reg} - {1'b0, step});

    always_ff @(posedge aclk) begin
        if (stage_en.blend) begin
            if (sat_f_reg || blend > (TANH_WIDTH+1)'(1) << Q30_SHIFT) begin
                tanh_mag_reg <= (TANH_WIDTH+1)'(1) << Q30_SHIFT;
            end else begin
                tanh_mag_reg <= blend;
            end
        end
    end

    assign tanh_mag = tanh_mag_reg;

endmodule

// ----- design/gelu_tanh_lut_activation_core.sv -----
// ----------------------------------------------------------------------------
// gelu_tanh_lut_activation_core
// GELU in its tanh form on signed fixed-point samples, fully pipelined.
// ----------------------------------------------------------------------------
// The core takes one item per cycle as long as the result side keeps taking
// items. There are ten register stages, each holding at most one multiplier:
// magnitude and sign, square, polynomial, two products for the tanh argument,
// table index, table fetch, interpolation, gain product and output saturation.
// Every stage holds its own valid bit, so bubbles close up under back-pressure
// and a waiting result does not keep new items out while earlier stages have
// room.
module gelu_tanh_lut_activation_core import glt_pkg::*; #(
    parameter int LUT_ENTRIES   = LUT_ENTRIES_DEF,
    parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // Fields from bit 0: sample.
    input  logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // Fields from bit 0: activated.
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   m_tdata
);

    localparam int W   = SAMPLE_WIDTH;
    localparam int F   = FRACTION_BITS;
    localparam int TDW = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int NS  = 10;
    localparam int AXW = F + 4;
    localparam int CW  = (W > AXW) ? W : AXW;
    localparam int SQW = F + 7;
    localparam int PW  = F + 2;
    localparam int XW  = F + 5;
    localparam int GW  = TANH_WIDTH + 2;
    localparam int MW  = W + 1;

    // Valid bits and stage readiness, stage 1 nearest the input.
    logic [NS:1] valid_reg;
    logic [NS:1] ready;

    always_comb begin
        ready[NS] = !valid_reg[NS] || m_tready;
        for (int k = NS - 1; k >= 1; k--) begin
            ready[k] = !valid_reg[k] || ready[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (ready[1]) begin
                valid_reg[1] <= s_tvalid;
            end
            for (int k = 2; k <= NS; k++) begin
                if (ready[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    assign s_tready = ready[1];

    // Stage 1: magnitude, sign and clamped tanh operand.
    logic [W-1:0]   raw;
    logic [W-1:0]   ax_in;
    logic [W-1:0]   ax_reg   [1:8];
    logic           neg_reg  [1:8];
    logic [AXW-1:0] axc_reg  [1:3];

    assign raw   = s_tdata[W-1:0];
    assign ax_in = raw[W-1] ? (W'(0) - raw) : raw;

    always_ff @(posedge aclk) begin
        if (ready[1]) begin
            ax_reg[1]  <= ax_in;
            neg_reg[1] <= raw[W-1];
            axc_reg[1] <= (CW'(ax_in) > CW'(8 << F)) ? AXW'(8 << F) : AXW'(ax_in);
        end
    end

    // Carry magnitude, sign and clamped operand down the pipe.
    for (genvar k = 2; k <= 8; k++) begin : g_carry
        always_ff @(posedge aclk) begin
            if (ready[k]) begin
                ax_reg[k]  <= ax_reg[k-1];
                neg_reg[k] <= neg_reg[k-1];
            end
        end
    end

    for (genvar k = 2; k <= 3; k++) begin : g_carry_axc
        always_ff @(posedge aclk) begin
            if (ready[k]) begin
                axc_reg[k] <= axc_reg[k-1];
            end
        end
    end

    // Stage 2: square of the clamped magnitude.
    logic [2*AXW-1:0] sq_prod;
    logic [SQW-1:0]   sq_reg;

    assign sq_prod = (2*AXW)'(axc_reg[1]) * (2*AXW)'(axc_reg[1]);

    always_ff @(posedge aclk) begin
        if (ready[2]) begin
            sq_reg <= sq_prod[F+SQW-1:F];
        end
    end

    // Stage 3: polynomial 1 + 0.044715 * x^2.
    logic [SQW+COEF_B_WIDTH-1:0] b_prod;
    logic [PW-1:0]               poly_reg;

    assign b_prod = (SQW+COEF_B_WIDTH)'(sq_reg) * (SQW+COEF_B_WIDTH)'(COEF_B);

    always_ff @(posedge aclk) begin
        if (ready[3]) begin
            poly_reg <= PW'(1 << F) + PW'(b_prod >> COEF_SHIFT);
        end
    end

    // Stage 4: magnitude times polynomial.
    logic [AXW+PW-1:0] x_prod;
    logic [XW-1:0]     xp_reg;

    assign x_prod = (AXW+PW)'(axc_reg[3]) * (AXW+PW)'(poly_reg);

    always_ff @(posedge aclk) begin
        if (ready[4]) begin
            xp_reg <= x_prod[F+XW-1:F];
        end
    end

    // Stage 5: scale by 0.797885 to form the tanh argument.
    logic [XW+COEF_A_WIDTH-1:0] a_prod;
    logic [XW-1:0]              arg_reg;

    assign a_prod = (XW+COEF_A_WIDTH)'(xp_reg) * (XW+COEF_A_WIDTH)'(COEF_A);

    always_ff @(posedge aclk) begin
        if (ready[5]) begin
            arg_reg <= a_prod[COEF_SHIFT+XW-1:COEF_SHIFT];
        end
    end

    // Stages 6 to 8: tanh magnitude from the table.
    glt_stage_en_t       tanh_en;
    logic [TANH_WIDTH:0] tanh_mag;

    assign tanh_en.index = ready[6];
    assign tanh_en.fetch = ready[7];
    assign tanh_en.blend = ready[8];

    glt_tanh_interp #(
        .LUT_ENTRIES   (LUT_ENTRIES),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_tanh (
        .aclk     (aclk),
        .stage_en (tanh_en),
        .arg      (arg_reg),
        .tanh_mag (tanh_mag)
    );

    // Stage 9: gain times magnitude, rounded half away from zero.
    logic [GW-1:0]   gain;
    logic [W+GW-1:0] m_prod;
    logic [MW-1:0]   mag_reg;
    logic            neg9_reg;

    assign gain   = neg_reg[8] ? (GW'(1) << Q30_SHIFT) - GW'(tanh_mag)
                               : (GW'(1) << Q30_SHIFT) + GW'(tanh_mag);
    assign m_prod = (W+GW)'(ax_reg[8]) * (W+GW)'(gain) + ((W+GW)'(1) << Q30_SHIFT);

    always_ff @(posedge aclk) begin
        if (ready[9]) begin
            mag_reg  <= m_prod[Q30_SHIFT+1+MW-1:Q30_SHIFT+1];
            neg9_reg <= neg_reg[8];
        end
    end

    // Stage 10: saturate, restore the sign and hold for the result side.
    logic [W-1:0] out_reg;
    logic [MW-1:0] neg_mag;

    assign neg_mag = (mag_reg > (MW'(1) << (W - 1))) ? (MW'(1) << (W - 1)) : mag_reg;

    always_ff @(posedge aclk) begin
        if (ready[10]) begin
            if (!neg9_reg) begin
                out_reg <= (mag_reg > MW'((1 << (W - 1)) - 1))
                           ? W'((1 << (W - 1)) - 1) : mag_reg[W-1:0];
            end else begin
                out_reg <= W'(0) - neg_mag[W-1:0];
            end
        end
    end

    assign m_tvalid = valid_reg[NS];
    assign m_tdata  = TDW'(out_reg);

endmodule

// ----- design/glt_checker.sv -----
// ----------------------------------------------------------------------------
// glt_checker
// Port-level checks for the GELU core, bound to the top level.
// ----------------------------------------------------------------------------
module glt_checker import glt_pkg::*; #(
    parameter int SAMPLE_WIDTH  = SAMPLE_WIDTH_DEF,
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_tvalid,
    input logic                                s_tready,
    input logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   s_tdata,
    input logic                                m_tvalid,
    input logic                                m_tready,
    input logic [((SAMPLE_WIDTH+7)/8)*8-1:0]   m_tdata
);

    // A waiting input item holds its value until it is taken.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("input item changed while waiting");

    // A stalled result item holds its value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    // Reset empties the pipeline.
    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // With nothing at the output, the whole pipeline has room.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output");

    // GELU never goes below about -0.17, so a result stays no lower than -0.25.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> $signed(m_tdata[SAMPLE_WIDTH-1:0]) >=
                     -$signed(SAMPLE_WIDTH'(1 << (FRACTION_BITS - 2))))
        else $error("result below GELU minimum");

endmodule

bind gelu_tanh_lut_activation_core glt_checker #(
    .SAMPLE_WIDTH  (SAMPLE_WIDTH),
    .FRACTION_BITS (FRACTION_BITS)
) u_glt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
